// ----- hw/rtl/kpv_pkg.sv -----
// ----------------------------------------------------------------------------
// kpv_pkg
// shared constants, types and the multiply schedule of the kalman predict block
// ----------------------------------------------------------------------------
package kpv_pkg;

    // fixed-point format and word widths
    localparam int DATA_W        = 32;
    localparam int FRAC_BITS     = 16;
    localparam int STEP_BITS_DEF = 8;
    localparam int TIME_STEP_W   = 8;

    localparam logic [DATA_W-1:0] ONE_FX      = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] NOISE_RESET = DATA_W'((64'd1 << FRAC_BITS) / 100);

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_ACCEL_NOISE       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INIT_POSITION     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INIT_VELOCITY     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INIT_POS_VARIANCE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INIT_VEL_VARIANCE = 3'd4;

    // multiply schedule: one product by dt per step, product k lands in term k
    localparam int NUM_STEPS  = 10;
    localparam int STEP_CNT_W = $clog2(NUM_STEPS);

    localparam logic [STEP_CNT_W-1:0] T_AD1  = 4'd0;  // a*dt
    localparam logic [STEP_CNT_W-1:0] T_AD2  = 4'd1;  // a*dt^2
    localparam logic [STEP_CNT_W-1:0] T_VD   = 4'd2;  // v*dt
    localparam logic [STEP_CNT_W-1:0] T_CD   = 4'd3;  // c*dt
    localparam logic [STEP_CNT_W-1:0] T_PVD1 = 4'd4;  // pvv*dt
    localparam logic [STEP_CNT_W-1:0] T_PVD2 = 4'd5;  // pvv*dt^2
    localparam logic [STEP_CNT_W-1:0] T_Q1   = 4'd6;  // q*dt
    localparam logic [STEP_CNT_W-1:0] T_Q2   = 4'd7;  // q*dt^2
    localparam logic [STEP_CNT_W-1:0] T_Q3   = 4'd8;  // q*dt^3
    localparam logic [STEP_CNT_W-1:0] T_Q4   = 4'd9;  // q*dt^4

    // multiplier operand select
    localparam int OP_W = 3;

    localparam logic [OP_W-1:0] OP_ACCEL = 3'd0;
    localparam logic [OP_W-1:0] OP_PROD  = 3'd1;
    localparam logic [OP_W-1:0] OP_VEL   = 3'd2;
    localparam logic [OP_W-1:0] OP_COV   = 3'd3;
    localparam logic [OP_W-1:0] OP_PVV   = 3'd4;
    localparam logic [OP_W-1:0] OP_NOISE = 3'd5;

    typedef struct packed {
        logic [DATA_W-1:0] accel_noise;
        logic [DATA_W-1:0] init_position;
        logic [DATA_W-1:0] init_velocity;
        logic [DATA_W-1:0] init_pos_variance;
        logic [DATA_W-1:0] init_vel_variance;
    } kpv_cfg_t;

    typedef struct packed {
        logic                  capture;
        logic                  mul_en;
        logic [OP_W-1:0]       op_sel;
        logic [STEP_CNT_W-1:0] step;
        logic                  sum_en;
        logic                  commit;
        logic                  reload;
    } kpv_cmd_t;

    function automatic logic [OP_W-1:0] step_op(input logic [STEP_CNT_W-1:0] step);
        logic [OP_W-1:0] op;
        case (step)
            T_AD1:   op = OP_ACCEL;
            T_AD2:   op = OP_PROD;
            T_VD:    op = OP_VEL;
            T_CD:    op = OP_COV;
            T_PVD1:  op = OP_PVV;
            T_PVD2:  op = OP_PROD;
            T_Q1:    op = OP_NOISE;
            T_Q2:    op = OP_PROD;
            T_Q3:    op = OP_PROD;
            T_Q4:    op = OP_PROD;
            default: op = OP_ACCEL;
        endcase
        return op;
    endfunction

endpackage

// ----- hw/rtl/kpv_regs.sv -----
// ----------------------------------------------------------------------------
// kpv_regs
// apb register file: process noise and the reload values
// ----------------------------------------------------------------------------
module kpv_regs import kpv_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    output kpv_cfg_t              cfg
);

    kpv_cfg_t             cfg_reg;
    kpv_cfg_t             cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_ACCEL_NOISE:       cfg_next.accel_noise       = pwdata;
                REG_INIT_POSITION:     cfg_next.init_position     = pwdata;
                REG_INIT_VELOCITY:     cfg_next.init_velocity     = pwdata;
                REG_INIT_POS_VARIANCE: cfg_next.init_pos_variance = pwdata;
                REG_INIT_VEL_VARIANCE: cfg_next.init_vel_variance = pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ACCEL_NOISE:       prdata = cfg_reg.accel_noise;
            REG_INIT_POSITION:     prdata = cfg_reg.init_position;
            REG_INIT_VELOCITY:     prdata = cfg_reg.init_velocity;
            REG_INIT_POS_VARIANCE: prdata = cfg_reg.init_pos_variance;
            REG_INIT_VEL_VARIANCE: prdata = cfg_reg.init_vel_variance;
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accel_noise       <= NOISE_RESET;
            cfg_reg.init_position     <= '0;
            cfg_reg.init_velocity     <= '0;
            cfg_reg.init_pos_variance <= ONE_FX;
            cfg_reg.init_vel_variance <= ONE_FX;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/kpv_ctrl.sv -----
// ----------------------------------------------------------------------------
// kpv_ctrl
// sequencer: accepts a word, steps the shared multiplier, sums, commits
// ----------------------------------------------------------------------------
module kpv_ctrl import kpv_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     s_func,
    output logic     s_tready,
    input  logic     m_tready,
    output logic     m_tvalid,
    output kpv_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MUL    = 2'd1;
    localparam logic [1:0] ST_SUM    = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(NUM_STEPS - 1);

    logic [1:0]            state_reg, state_next;
    logic [STEP_CNT_W-1:0] step_reg, step_next;
    logic                  func_reg, func_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        func_next    = func_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        cmd          = '0;
        cmd.op_sel   = step_op(step_reg);
        cmd.step     = step_reg;
        cmd.reload   = func_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    func_next   = s_func;
                    step_next   = '0;
                    state_next  = s_func ? ST_COMMIT : ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = ST_SUM;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SUM: begin
                cmd.sum_en = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold until the previous result has left the output
                if (!m_valid_reg || m_tready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            func_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            func_reg    <= func_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- hw/rtl/kpv_dp.sv -----
// ----------------------------------------------------------------------------
// kpv_dp
// datapath: filter state, shared multiply-by-dt unit, term sums, saturation
// ----------------------------------------------------------------------------
module kpv_dp import kpv_pkg::*; #(
    parameter int STEP_BITS = STEP_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  kpv_cmd_t               cmd,
    input  kpv_cfg_t               cfg,
    input  logic [DATA_W-1:0]      accel_in,
    input  logic [TIME_STEP_W-1:0] time_step,
    output logic [DATA_W-1:0]      position_out,
    output logic [DATA_W-1:0]      velocity_out,
    output logic [DATA_W-1:0]      pos_variance_out,
    output logic [DATA_W-1:0]      vel_variance_out,
    output logic [DATA_W-1:0]      covariance_out,
    output logic                   saturated
);

    // term width: exact for one product by dt, clamped beyond that; a clamped
    // term is far enough out that the final value saturates the same way
    localparam int XW = DATA_W + STEP_BITS + 4;
    localparam int PW = XW + STEP_BITS + 1;
    localparam int SW = XW + 3;

    localparam logic [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] U32_MAX = {DATA_W{1'b1}};

    logic [DATA_W-1:0]     position_reg, velocity_reg, pos_var_reg, vel_var_reg, cov_reg;
    logic                  sat_reg;
    logic [DATA_W-1:0]     accel_reg;
    logic [STEP_BITS-1:0]  dt_reg;
    logic signed [XW-1:0]  prod_reg, prod_next;
    logic signed [XW-1:0]  terms_reg [NUM_STEPS];
    logic signed [SW-1:0]  pos_sum_reg, vel_sum_reg, pvar_sum_reg, vvar_sum_reg, cov_sum_reg;
    logic signed [SW-1:0]  pos_sum_next, vel_sum_next, pvar_sum_next, vvar_sum_next;
    logic signed [SW-1:0]  cov_sum_next;
    logic signed [XW-1:0]  op;
    logic signed [PW-1:0]  prod_full;
    logic [PW-XW:0]        prod_hi;
    logic [DATA_W:0]       pos_sat, vel_sat, pvar_sat, vvar_sat, cov_sat;

    function automatic logic signed [XW-1:0] sext_x(input logic [DATA_W-1:0] x);
        return {{(XW-DATA_W){x[DATA_W-1]}}, x};
    endfunction

    function automatic logic signed [XW-1:0] zext_x(input logic [DATA_W-1:0] x);
        return {{(XW-DATA_W){1'b0}}, x};
    endfunction

    function automatic logic signed [SW-1:0] ext_s(input logic signed [XW-1:0] x);
        return SW'(x);
    endfunction

    // {flag, value}
    function automatic logic [DATA_W:0] sat_s(input logic signed [SW-1:0] v);
        logic [SW-DATA_W:0] hi;
        hi = v[SW-1:DATA_W-1];
        if ((&hi) || !(|hi)) begin
            return {1'b0, v[DATA_W-1:0]};
        end
        return {1'b1, v[SW-1] ? S32_MIN : S32_MAX};
    endfunction

    function automatic logic [DATA_W:0] sat_u(input logic signed [SW-1:0] v);
        if (v[SW-1]) begin
            return {1'b1, {DATA_W{1'b0}}};
        end
        if (|v[SW-1:DATA_W]) begin
            return {1'b1, U32_MAX};
        end
        return {1'b0, v[DATA_W-1:0]};
    endfunction

    // operand select for the shared multiplier
    always_comb begin
        case (cmd.op_sel)
            OP_ACCEL: op = sext_x(accel_reg);
            OP_PROD:  op = prod_reg;
            OP_VEL:   op = sext_x(velocity_reg);
            OP_COV:   op = sext_x(cov_reg);
            OP_PVV:   op = zext_x(vel_var_reg);
            OP_NOISE: op = zext_x(cfg.accel_noise);
            default:  op = '0;
        endcase
    end

    assign prod_full = PW'(op) * PW'($signed({1'b0, dt_reg}));
    assign prod_hi   = prod_full[PW-1:XW-1];

    always_comb begin
        if ((&prod_hi) || !(|prod_hi)) begin
            prod_next = prod_full[XW-1:0];
        end else if (prod_full[PW-1]) begin
            prod_next = {1'b1, {(XW-1){1'b0}}};
        end else begin
            prod_next = {1'b0, {(XW-1){1'b1}}};
        end
    end

    // term sums, halving and quartering round toward minus infinity
    always_comb begin
        vel_sum_next  = SW'($signed(velocity_reg)) + ext_s(terms_reg[T_AD1]);
        pos_sum_next  = SW'($signed(position_reg)) + ext_s(terms_reg[T_VD])
                      + (ext_s(terms_reg[T_AD2]) >>> 1);
        pvar_sum_next = SW'($signed({1'b0, pos_var_reg})) + ext_s(terms_reg[T_PVD2])
                      + (ext_s(terms_reg[T_Q4]) >>> 2) + (ext_s(terms_reg[T_CD]) <<< 1);
        vvar_sum_next = SW'($signed({1'b0, vel_var_reg})) + ext_s(terms_reg[T_Q2]);
        cov_sum_next  = ext_s(terms_reg[T_PVD1]) + (ext_s(terms_reg[T_Q3]) >>> 1)
                      + SW'($signed(cov_reg));
    end

    assign pos_sat  = sat_s(pos_sum_reg);
    assign vel_sat  = sat_s(vel_sum_reg);
    assign pvar_sat = sat_u(pvar_sum_reg);
    assign vvar_sat = sat_u(vvar_sum_reg);
    assign cov_sat  = sat_s(cov_sum_reg);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            accel_reg <= accel_in;
            dt_reg    <= STEP_BITS'(time_step);
        end
        if (cmd.mul_en) begin
            prod_reg              <= prod_next;
            terms_reg[cmd.step]   <= prod_next;
        end
        if (cmd.sum_en) begin
            pos_sum_reg  <= pos_sum_next;
            vel_sum_reg  <= vel_sum_next;
            pvar_sum_reg <= pvar_sum_next;
            vvar_sum_reg <= vvar_sum_next;
            cov_sum_reg  <= cov_sum_next;
        end
    end

    // filter state, also the result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            velocity_reg <= '0;
            pos_var_reg  <= ONE_FX;
            vel_var_reg  <= ONE_FX;
            cov_reg      <= '0;
            sat_reg      <= 1'b0;
        end else if (cmd.commit) begin
            if (cmd.reload) begin
                position_reg <= cfg.init_position;
                velocity_reg <= cfg.init_velocity;
                pos_var_reg  <= cfg.init_pos_variance;
                vel_var_reg  <= cfg.init_vel_variance;
                cov_reg      <= '0;
                sat_reg      <= 1'b0;
            end else begin
                position_reg <= pos_sat[DATA_W-1:0];
                velocity_reg <= vel_sat[DATA_W-1:0];
                pos_var_reg  <= pvar_sat[DATA_W-1:0];
                vel_var_reg  <= vvar_sat[DATA_W-1:0];
                cov_reg      <= cov_sat[DATA_W-1:0];
                sat_reg      <= pos_sat[DATA_W] | vel_sat[DATA_W] | pvar_sat[DATA_W]
                              | vvar_sat[DATA_W] | cov_sat[DATA_W];
            end
        end
    end

    assign position_out     = position_reg;
    assign velocity_out     = velocity_reg;
    assign pos_variance_out = pos_var_reg;
    assign vel_variance_out = vel_var_reg;
    assign covariance_out   = cov_reg;
    assign saturated        = sat_reg;

endmodule

// ----- hw/rtl/kalman_predict_pos_vel_top.sv -----
// ----------------------------------------------------------------------------
// kalman_predict_pos_vel_top
// one-axis kalman predict step, position and velocity, q16.16 fixed point.
// each input word carries an acceleration and an integer tick count dt; the
// block advances position, velocity, both variances and the covariance and
// returns all five as one result word, clamping any value that leaves its
// 32-bit range and raising the saturated flag in tuser. a word with the reload
// flag set copies the initial-value registers into the state instead (covariance
// zero, flag clear). a predict word passes from acceptance through the single shared
// multiplier (every term is a state value times dt, dt^2, dt^3 or dt^4, built one
// product by dt per cycle), then a state that adds the terms and one that saturates
// and stores. a reload word goes from acceptance straight to the store. the result
// sits in the state registers, so the next word is taken and multiplied while a
// result still waits on m_tready; only the final store waits for it to leave. only
// the low STEP_BITS bits of time_step are used.
// registers: 0x00 accel_noise, 0x04 init_position, 0x08 init_velocity,
// 0x0c init_pos_variance, 0x10 init_vel_variance; write them only while idle.
// ----------------------------------------------------------------------------
module kalman_predict_pos_vel_top import kpv_pkg::*; #(
    parameter int STEP_BITS = STEP_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input word
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // accel_in[31:0], time_step[39:32]
    input  logic [0:0]            s_tuser,   // func[0]: 1 reloads the state
    // result word
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [159:0]          m_tdata,   // position_out[31:0], velocity_out[63:32],
                                             // pos_variance_out[95:64],
                                             // vel_variance_out[127:96],
                                             // covariance_out[159:128]
    output logic [0:0]            m_tuser,   // saturated[0]
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    kpv_cfg_t          cfg;
    kpv_cmd_t          cmd;
    logic [DATA_W-1:0] position_out, velocity_out, pos_variance_out;
    logic [DATA_W-1:0] vel_variance_out, covariance_out;
    logic              saturated;

    // register file
    kpv_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer owns both handshakes
    kpv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_func   (s_tuser[0]),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    // state, multiplier and sums
    kpv_dp #(
        .STEP_BITS (STEP_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg              (cfg),
        .accel_in         (s_tdata[31:0]),
        .time_step        (s_tdata[39:32]),
        .position_out     (position_out),
        .velocity_out     (velocity_out),
        .pos_variance_out (pos_variance_out),
        .vel_variance_out (vel_variance_out),
        .covariance_out   (covariance_out),
        .saturated        (saturated)
    );

    // result word is the stored state
    assign m_tdata = {covariance_out, vel_variance_out, pos_variance_out,
                      velocity_out, position_out};
    assign m_tuser = saturated;

    // no input taken while the multiplier is stepping
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_en |-> !s_tready)
        else $error("input accepted during multiply sequence");

    // every store raises a result
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("stored state without a result");

    // a reload reports zero covariance and no clamp
    a_reload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && cmd.reload) |=> (!m_tuser[0] && (m_tdata[159:128] == '0)))
        else $error("reload result carries covariance or flag");

    // a result appears only from a store
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("result raised without a store");

endmodule

// ----- tb/sv/tb_kalman_predict_pos_vel_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kalman_predict_pos_vel_top
// self-checking bench for the one-axis kalman predict block. a short table of
// corner words runs first, then random predict and reload words under three
// register settings and three stall mixes. every result word is checked field
// by field against a bit-true track model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_kalman_predict_pos_vel_top;
    import kpv_pkg::*;

    // ------------------------------------------------------------------------
    // types and constants
    // ------------------------------------------------------------------------

    // one result word, packed exactly as {m_tuser, m_tdata}
    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] cov;
        logic [DATA_W-1:0] vvar;
        logic [DATA_W-1:0] pvar;
        logic [DATA_W-1:0] vel;
        logic [DATA_W-1:0] pos;
    } estimate_t;

    // one row of the corner table; want is used only where typed is set
    typedef struct packed {
        logic                   reload;
        logic [DATA_W-1:0]      accel;
        logic [TIME_STEP_W-1:0] ticks;
        logic                   typed;
        estimate_t              want;
    } probe_t;

    localparam int              SETTLE_CYCLES = 20;    // quiet time after the last owed result
    localparam longint unsigned TERM_CAP      = 64'd1 << 62;
    localparam logic [TIME_STEP_W-1:0] STEP_MASK = TIME_STEP_W'((1 << STEP_BITS_DEF) - 1);

    // an address past the last register, writes there must be dropped
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd5;

    // state right after reset, and after a reload with reset register values
    localparam estimate_t AT_RESET = '{1'b0, 32'h0, ONE_FX, ONE_FX, 32'h0, 32'h0};

    // corner words: zero step, reloads with junk fields, halving toward minus
    // infinity, both accel extremes with the largest step, covariance driving
    // the position variance into its clamp, alternating bit patterns
    localparam probe_t PROBES [22] = '{
        '{1'b0, 32'h1234_5678, 8'd0,   1'b1, AT_RESET},
        '{1'b1, 32'hFFFF_FFFF, 8'hFF,  1'b1, AT_RESET},
        '{1'b0, 32'h0001_0000, 8'd1,   1'b0, '0},
        '{1'b0, 32'hFFFF_FFFF, 8'd1,   1'b0, '0},
        '{1'b0, 32'hFFFF_FFFD, 8'd3,   1'b0, '0},
        '{1'b0, 32'h0000_0001, 8'd1,   1'b0, '0},
        '{1'b0, 32'h7FFF_FFFF, 8'd255, 1'b0, '0},
        '{1'b0, 32'h8000_0000, 8'd0,   1'b0, '0},
        '{1'b0, 32'h8000_0000, 8'd255, 1'b0, '0},
        '{1'b0, 32'h0000_0000, 8'd255, 1'b0, '0},
        '{1'b0, 32'h0000_0000, 8'd255, 1'b0, '0},
        '{1'b1, 32'h0000_0000, 8'd0,   1'b1, AT_RESET},
        '{1'b0, 32'hFFFF_0000, 8'd128, 1'b0, '0},
        '{1'b0, 32'h0000_8000, 8'd64,  1'b0, '0},
        '{1'b0, 32'h0000_0000, 8'd1,   1'b0, '0},
        '{1'b1, 32'h5555_5555, 8'h55,  1'b1, AT_RESET},
        '{1'b0, 32'h5555_5555, 8'h55,  1'b0, '0},
        '{1'b0, 32'hAAAA_AAAA, 8'hAA,  1'b0, '0},
        '{1'b0, 32'h0000_FFFF, 8'd2,   1'b0, '0},
        '{1'b0, 32'h0000_0000, 8'd0,   1'b0, '0},
        '{1'b1, 32'hAAAA_AAAA, 8'hAA,  1'b1, AT_RESET},
        '{1'b0, 32'h0000_0000, 8'd0,   1'b1, AT_RESET}
    };

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [39:0]           s_tdata;    // accel_in[31:0], time_step[39:32]
    logic [0:0]            s_tuser;    // func[0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [159:0]          m_tdata;    // position, velocity, pos_variance,
                                       // vel_variance, covariance (32 bits each)
    logic [0:0]            m_tuser;    // saturated[0]
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // bench-side copy of the registers and of the track state
    logic [DATA_W-1:0] cfg_shadow [0:4];
    logic [DATA_W-1:0] trk_pos, trk_vel, trk_pvar, trk_vvar, trk_cov;

    // results still owed by the block, oldest first
    estimate_t pending_estimates [$];

    // stall mix, percent of cycles each side holds off
    int tx_idle_pct;
    int rx_idle_pct;

    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned reloads_sent;
    int unsigned estimates_seen;
    int unsigned clamped_seen;

    // ------------------------------------------------------------------------
    // clock and block under test
    // ------------------------------------------------------------------------
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    kalman_predict_pos_vel_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // track model arithmetic
    // ------------------------------------------------------------------------

    // every intermediate is held exactly or pinned at 2^62, far past 32 bits
    function automatic longint unsigned mul_cap(input longint unsigned x,
                                                input longint unsigned y);
        if (x == 0 || y == 0) return 0;
        if (y > TERM_CAP / x) return TERM_CAP;
        return (x * y > TERM_CAP) ? TERM_CAP : x * y;
    endfunction

    function automatic longint unsigned add_cap(input longint unsigned x,
                                                input longint unsigned y);
        return (x + y > TERM_CAP) ? TERM_CAP : x + y;
    endfunction

    // {clamped, value}
    function automatic logic [32:0] clamp_signed(input longint val);
        if (val > 64'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
        if (val < -64'sd2147483648) return {1'b1, 32'h8000_0000};
        return {1'b0, val[31:0]};
    endfunction

    function automatic logic [32:0] clamp_unsigned(input longint val);
        if (val < 0) return {1'b1, 32'h0};
        if (val > 64'sd4294967295) return {1'b1, 32'hFFFF_FFFF};
        return {1'b0, val[31:0]};
    endfunction

    // advances the track by one input word and returns the word it reports;
    // all terms use the state as it was before this word
    function automatic estimate_t advance_track(input logic reload,
                                                input logic [DATA_W-1:0] accel,
                                                input logic [TIME_STEP_W-1:0] ticks);
        estimate_t       est;
        logic [32:0]     r;
        logic            clamped;
        longint          sdt, a, p, v, c, ad2, vnew, pnew;
        longint unsigned udt, dt2, dt3, dt4, pvv, q, pos_part, vv_part, cov_part;
        clamped = 1'b0;
        if (reload) begin
            trk_pos  = cfg_shadow[REG_INIT_POSITION];
            trk_vel  = cfg_shadow[REG_INIT_VELOCITY];
            trk_pvar = cfg_shadow[REG_INIT_POS_VARIANCE];
            trk_vvar = cfg_shadow[REG_INIT_VEL_VARIANCE];
            trk_cov  = '0;
        end else begin
            udt = 64'(ticks & STEP_MASK);
            sdt = longint'(udt);
            a   = longint'(signed'(accel));
            p   = longint'(signed'(trk_pos));
            v   = longint'(signed'(trk_vel));
            c   = longint'(signed'(trk_cov));
            pvv = 64'(trk_vvar);
            q   = 64'(cfg_shadow[REG_ACCEL_NOISE]);
            dt2 = udt * udt;
            dt3 = dt2 * udt;
            dt4 = dt2 * dt2;
            ad2 = a * sdt * sdt;
            vnew = v + a * sdt;
            // arithmetic shift gives the halving toward minus infinity
            pnew = p + v * sdt + (ad2 >>> 1);
            pos_part = add_cap(add_cap(64'(trk_pvar), mul_cap(dt2, pvv)),
                               mul_cap(dt4, q) >> 2);
            vv_part  = add_cap(pvv, mul_cap(dt2, q));
            cov_part = add_cap(mul_cap(udt, pvv), mul_cap(dt3, q) >> 1);

            r = clamp_signed(pnew);                               trk_pos  = r[31:0]; clamped |= r[32];
            r = clamp_signed(vnew);                               trk_vel  = r[31:0]; clamped |= r[32];
            r = clamp_unsigned(longint'(pos_part) + 2 * c * sdt); trk_pvar = r[31:0]; clamped |= r[32];
            r = clamp_unsigned(longint'(vv_part));                trk_vvar = r[31:0]; clamped |= r[32];
            r = clamp_signed(longint'(cov_part) + c);             trk_cov  = r[31:0]; clamped |= r[32];
        end
        est.pos  = trk_pos;
        est.vel  = trk_vel;
        est.pvar = trk_pvar;
        est.vvar = trk_vvar;
        est.cov  = trk_cov;
        est.sat  = clamped;
        return est;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("[%0t] result word %0d: %s got %08h want %08h",
                 $time, estimates_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_estimate(input estimate_t got);
        estimate_t want;
        string     names [5];
        names = '{"position", "velocity", "pos_variance", "vel_variance", "covariance"};
        if (pending_estimates.size() == 0) begin
            report_mismatch("unexpected result word", got.pos, '0);
        end else begin
            want = pending_estimates.pop_front();
            for (int k = 0; k < 5; k++) begin
                if (got[32*k +: 32] !== want[32*k +: 32])
                    report_mismatch(names[k], got[32*k +: 32], want[32*k +: 32]);
            end
            if (got.sat !== want.sat)
                report_mismatch("saturated", 32'(got.sat), 32'(want.sat));
        end
    endtask

    // result words are taken at the rising edge where valid meets ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_estimate({m_tuser, m_tdata});
            estimates_seen++;
            if (m_tuser[0]) clamped_seen++;
        end
    end

    // receiver holds off at random according to the current mix
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // offers one input word; valid stays high after acceptance until the next
    // word or an idle cycle replaces it, so it is never dropped and raised in
    // the same step
    task automatic push_item(input logic reload, input logic [DATA_W-1:0] accel,
                             input logic [TIME_STEP_W-1:0] ticks, input logic typed,
                             input estimate_t want);
        estimate_t est;
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {8'($urandom), $urandom};
            s_tuser  <= 1'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ticks, accel};
        s_tuser  <= reload;
        do @(posedge aclk); while (!s_tready);
        est = advance_track(reload, accel, ticks);
        pending_estimates.push_back(typed ? want : est);
        items_sent++;
        if (reload) reloads_sent++;
    endtask

    // drops valid, waits for every owed result, then lets the block go quiet
    task automatic settle_block(input int extra_cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge aclk);
        repeat (extra_cycles) @(posedge aclk);
    endtask

    // two-phase register write; the shadow copy follows mapped addresses only
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= REG_INIT_VEL_VARIANCE) cfg_shadow[idx] = value;
    endtask

    // random words: mostly short runs of predicts with modest accel and small
    // steps, each run opened by a reload, with full-range words mixed in so
    // every field bit toggles; a pause halfway lets the block drain empty
    task automatic run_phase(input int words, input int tx_pct, input int rx_pct);
        logic [DATA_W-1:0]      accel;
        logic [TIME_STEP_W-1:0] ticks;
        int                     pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        push_item(1'b1, $urandom, 8'($urandom), 1'b0, '0);
        for (int i = 0; i < words; i++) begin
            if (i == words / 2) settle_block(0);
            if ($urandom_range(0, 7) == 0) accel = $urandom;
            else accel = 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
            pick = $urandom_range(0, 9);
            if (pick < 7)      ticks = 8'($urandom_range(0, 4));
            else if (pick < 9) ticks = 8'($urandom_range(5, 32));
            else               ticks = 8'($urandom_range(0, 255));
            push_item($urandom_range(0, 99) < 10, accel, ticks, 1'b0, '0);
        end
        settle_block(SETTLE_CYCLES);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        tx_idle_pct = 36;
        rx_idle_pct = 87;
        mismatch_count = 0;
        items_sent     = 0;
        reloads_sent   = 0;
        estimates_seen = 0;
        clamped_seen   = 0;

        // register and track values after reset
        cfg_shadow[REG_ACCEL_NOISE]       = NOISE_RESET;
        cfg_shadow[REG_INIT_POSITION]     = '0;
        cfg_shadow[REG_INIT_VELOCITY]     = '0;
        cfg_shadow[REG_INIT_POS_VARIANCE] = ONE_FX;
        cfg_shadow[REG_INIT_VEL_VARIANCE] = ONE_FX;
        trk_pos  = '0;
        trk_vel  = '0;
        trk_pvar = ONE_FX;
        trk_vvar = ONE_FX;
        trk_cov  = '0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // corner table under reset register values
        for (int i = 0; i < $size(PROBES); i++)
            push_item(PROBES[i].reload, PROBES[i].accel, PROBES[i].ticks,
                      PROBES[i].typed, PROBES[i].want);
        settle_block(SETTLE_CYCLES);

        // moderate random settings, sender 36 / receiver 87
        write_reg(REG_ACCEL_NOISE, $urandom_range(0, 32'h2_0000));
        write_reg(REG_INIT_POSITION, 32'($urandom_range(0, 32'h200_0000)) - 32'h100_0000);
        write_reg(REG_INIT_VELOCITY, 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000);
        write_reg(REG_INIT_POS_VARIANCE, $urandom_range(0, 32'h10_0000));
        write_reg(REG_INIT_VEL_VARIANCE, $urandom_range(0, 32'h10_0000));
        run_phase(230, 36, 87);

        // low extremes, sender 87 / receiver 36
        write_reg(REG_ACCEL_NOISE, 32'h0);
        write_reg(REG_INIT_POSITION, 32'h8000_0000);
        write_reg(REG_INIT_VELOCITY, 32'h7FFF_FFFF);
        write_reg(REG_INIT_POS_VARIANCE, 32'h0);
        write_reg(REG_INIT_VEL_VARIANCE, 32'h0);
        run_phase(230, 87, 36);

        // high extremes plus a dropped write past the map, no stalls at all
        write_reg(REG_ACCEL_NOISE, 32'hFFFF_FFFF);
        write_reg(REG_INIT_POSITION, 32'h7FFF_FFFF);
        write_reg(REG_INIT_VELOCITY, 32'h8000_0000);
        write_reg(REG_INIT_POS_VARIANCE, 32'hFFFF_FFFF);
        write_reg(REG_INIT_VEL_VARIANCE, 32'hFFFF_FFFF);
        write_reg(REG_UNMAPPED, 32'h1234_5678);
        run_phase(230, 0, 0);

        $display("run covered %0d input words (%0d reloads), %0d result words, %0d clamped",
                 items_sent, reloads_sent, estimates_seen, clamped_seen);
        $display("three register settings, both stall mixes and a stall-free pass");
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hang guard, many times the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d result words still owed", pending_estimates.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
